@@ sv/gtl_pkg.sv @@
`default_nettype none

package gtl_pkg;

   localparam int AREA_W   = 12;
   localparam int COORD_W  = 13;
   localparam int DIV_CNT_W = $clog2(AREA_W + 1);
   localparam int STEP_W   = 4;
   localparam int CSR_IDX_W = 2;

   localparam logic [AREA_W-1:0] AREA_X_RST = AREA_W'(0);
   localparam logic [AREA_W-1:0] AREA_Y_RST = AREA_W'(0);
   localparam logic [AREA_W-1:0] AREA_WIDTH_RST = AREA_W'(80);
   localparam logic [AREA_W-1:0] AREA_HEIGHT_RST = AREA_W'(24);

   localparam logic [CSR_IDX_W-1:0] CSR_AREA_X      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_AREA_Y      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_AREA_WIDTH  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_AREA_HEIGHT = 2'd3;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_LOAD,
      OP_SEARCH,
      OP_ROWS,
      OP_REM,
      OP_DIV_H,
      OP_DIV_STEP,
      OP_DIV_W,
      OP_DIV_R,
      OP_SETUP,
      OP_EMIT
   } op_type;

   typedef enum logic [2:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_NO_ITEM,
      COND_SEARCH,
      COND_DIV_MORE,
      COND_MORE
   } cond_type;

   typedef struct packed {
      op_type               op;
      cond_type             cond;
      logic [STEP_W-1:0]    target;
   } ucode_type;

   localparam logic [STEP_W-1:0] STEP_LOAD   = 4'd0;
   localparam logic [STEP_W-1:0] STEP_SEARCH = 4'd1;
   localparam logic [STEP_W-1:0] STEP_ROWS   = 4'd2;
   localparam logic [STEP_W-1:0] STEP_REM    = 4'd3;
   localparam logic [STEP_W-1:0] STEP_DIVH   = 4'd4;
   localparam logic [STEP_W-1:0] STEP_DIVH_L = 4'd5;
   localparam logic [STEP_W-1:0] STEP_DIVW   = 4'd6;
   localparam logic [STEP_W-1:0] STEP_DIVW_L = 4'd7;
   localparam logic [STEP_W-1:0] STEP_DIVR   = 4'd8;
   localparam logic [STEP_W-1:0] STEP_DIVR_L = 4'd9;
   localparam logic [STEP_W-1:0] STEP_SETUP  = 4'd10;
   localparam logic [STEP_W-1:0] STEP_EMIT   = 4'd11;
   localparam logic [STEP_W-1:0] STEP_END    = 4'd12;

   function automatic ucode_type ucode_rom(input logic [STEP_W-1:0] step);
      ucode_type w;
      unique case (step)
         STEP_LOAD:   w = '{op: OP_LOAD,     cond: COND_NO_ITEM,  target: STEP_LOAD};
         STEP_SEARCH: w = '{op: OP_SEARCH,   cond: COND_SEARCH,   target: STEP_SEARCH};
         STEP_ROWS:   w = '{op: OP_ROWS,     cond: COND_NEVER,    target: STEP_LOAD};
         STEP_REM:    w = '{op: OP_REM,      cond: COND_NEVER,    target: STEP_LOAD};
         STEP_DIVH:   w = '{op: OP_DIV_H,    cond: COND_NEVER,    target: STEP_LOAD};
         STEP_DIVH_L: w = '{op: OP_DIV_STEP, cond: COND_DIV_MORE, target: STEP_DIVH_L};
         STEP_DIVW:   w = '{op: OP_DIV_W,    cond: COND_NEVER,    target: STEP_LOAD};
         STEP_DIVW_L: w = '{op: OP_DIV_STEP, cond: COND_DIV_MORE, target: STEP_DIVW_L};
         STEP_DIVR:   w = '{op: OP_DIV_R,    cond: COND_NEVER,    target: STEP_LOAD};
         STEP_DIVR_L: w = '{op: OP_DIV_STEP, cond: COND_DIV_MORE, target: STEP_DIVR_L};
         STEP_SETUP:  w = '{op: OP_SETUP,    cond: COND_NEVER,    target: STEP_LOAD};
         STEP_EMIT:   w = '{op: OP_EMIT,     cond: COND_MORE,     target: STEP_EMIT};
         STEP_END:    w = '{op: OP_NOP,      cond: COND_ALWAYS,   target: STEP_LOAD};
         default:     w = '{op: OP_NOP,      cond: COND_ALWAYS,   target: STEP_LOAD};
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

@@ sv/grid_tile_layout.sv @@
// Near-square grid tiling of a configured screen area.
// csr_ port: write area_x, area_y, area_width, area_height (index 0..3) while
// the block is idle; a write lands at the clock edge where csr_we is high.
// req_ channel: one beat carries a tile count; counts above MAX_TILES are
// clamped, and a count of zero yields no response beats.
// rsp_ channel: one beat per tile in row order with its position, size, left
// border flag, junction glyph and last_tile on the final beat.
// A microcoded sequencer runs one item at a time: a column search, the rows
// and remainder steps, three restoring divisions (height by rows, width by
// cols, width by the short last row's length), a setup step, then one tile
// per cycle while rsp_ready is high. req_ready is high only at the program's
// load step.
// The result register holds a beat while rsp_ready is low and the program
// waits at its emit step. Reset clears the sequencer, drops any pending beat
// and restores the area registers to 0, 0, 80, 24.
`default_nettype none

module grid_tile_layout #(
   parameter int MAX_TILES = 64
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [6:0]                    req_tile_count,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [gtl_pkg::COORD_W-1:0]        rsp_tile_x,
   output logic [gtl_pkg::COORD_W-1:0]        rsp_tile_y,
   output logic [gtl_pkg::AREA_W-1:0]         rsp_tile_width,
   output logic [gtl_pkg::AREA_W-1:0]         rsp_tile_height,
   output logic                               rsp_has_border,
   output logic                               rsp_junction_plus,
   output logic                               rsp_last_tile,
   input  wire logic                          csr_we,
   input  wire logic [gtl_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [gtl_pkg::AREA_W-1:0]    csr_wdata
);

   localparam int CW = $clog2(MAX_TILES + 1);
   localparam int NW = (CW > 7) ? CW : 7;
   localparam int PW = 2 * CW;
   localparam int AW = gtl_pkg::AREA_W;
   localparam int XW = gtl_pkg::COORD_W;

   logic [AW-1:0] area_x_ff, area_x_in;
   logic [AW-1:0] area_y_ff, area_y_in;
   logic [AW-1:0] area_w_ff, area_w_in;
   logic [AW-1:0] area_h_ff, area_h_in;

   logic [gtl_pkg::STEP_W-1:0] step_ff, step_in;

   logic [CW-1:0] n_ff, n_in;
   logic [CW-1:0] cols_ff, cols_in;
   logic [CW-1:0] rows_ff, rows_in;
   logic [CW-1:0] rem_ff, rem_in;
   logic [AW-1:0] nw_ff, nw_in;
   logic [AW-1:0] nh_ff, nh_in;
   logic [AW-1:0] nwr_ff, nwr_in;
   logic [CW-1:0] lw_ff, lw_in;
   logic [CW-1:0] lh_ff, lh_in;
   logic [CW-1:0] lr_ff, lr_in;

   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] col_ff, col_in;
   logic [CW-1:0] row_ff, row_in;
   logic [AW-1:0] xacc_ff, xacc_in;
   logic [AW-1:0] yacc_ff, yacc_in;

   logic [AW-1:0]                div_num_ff, div_num_in;
   logic [CW-1:0]                div_den_ff, div_den_in;
   logic [CW-1:0]                div_rem_ff, div_rem_in;
   logic [gtl_pkg::DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [XW-1:0] rsp_x_ff, rsp_x_in;
   logic [XW-1:0] rsp_y_ff, rsp_y_in;
   logic [AW-1:0] rsp_w_ff, rsp_w_in;
   logic [AW-1:0] rsp_h_ff, rsp_h_in;
   logic          rsp_border_ff, rsp_border_in;
   logic          rsp_plus_ff, rsp_plus_in;
   logic          rsp_last_ff, rsp_last_in;

   gtl_pkg::ucode_type uw;

   logic [NW-1:0] count_ext;
   logic [CW-1:0] n_sat;
   logic [CW-1:0] mul_a;
   logic [CW-1:0] mul_b;
   logic [PW-1:0] prod;
   logic [CW-1:0] last_cnt;
   logic [CW:0]   div_part;
   logic          div_ge;
   logic          accept;
   logic          fire;
   logic          last_row;
   logic          last_col;
   logic          is_last;
   logic          short_last;
   logic          border;
   logic          tee;
   logic [AW-1:0] nw_sel;
   logic [AW-1:0] aw;
   logic [AW-1:0] ah;
   logic [AW-1:0] w_full;
   logic          jump;

   assign uw = gtl_pkg::ucode_rom(step_ff);

   assign req_ready = (uw.op == gtl_pkg::OP_LOAD);
   assign accept    = req_valid && req_ready;
   assign fire      = !rsp_valid_ff || rsp_ready;

   assign count_ext = NW'(req_tile_count);
   assign n_sat     = (count_ext > NW'(MAX_TILES)) ? CW'(MAX_TILES) : CW'(count_ext);

   always_comb begin
      case (uw.op)
         gtl_pkg::OP_ROWS: begin
            mul_a = cols_ff - CW'(1);
            mul_b = cols_ff;
         end
         gtl_pkg::OP_REM: begin
            mul_a = rows_ff - CW'(1);
            mul_b = cols_ff;
         end
         default: begin
            mul_a = cols_ff;
            mul_b = cols_ff;
         end
      endcase
   end

   assign prod     = PW'(mul_a) * PW'(mul_b);
   assign last_cnt = CW'(PW'(n_ff) - prod);

   assign div_part = {div_rem_ff, div_num_ff[AW-1]};
   assign div_ge   = (div_part >= {1'b0, div_den_ff});

   assign last_row   = (row_ff == rows_ff - CW'(1));
   assign last_col   = (col_ff == cols_ff - CW'(1));
   assign is_last    = (idx_ff == n_ff - CW'(1));
   assign short_last = last_row && (rem_ff != '0) && (rows_ff > CW'(1));
   assign nw_sel     = short_last ? nwr_ff : nw_ff;
   assign border     = (col_ff != '0);
   assign tee        = (idx_ff <= cols_ff) ||
                       (last_row && (rem_ff != '0) && (cols_ff[0] ^ rem_ff[0]));
   assign ah         = last_row ? AW'(lh_ff) : '0;
   assign w_full     = nw_sel + aw;

   always_comb begin
      if ((rows_ff > CW'(1)) && is_last && (rem_ff > CW'(1))) begin
         aw = AW'(lr_ff);
      end else if (last_col) begin
         aw = AW'(lw_ff);
      end else begin
         aw = '0;
      end
   end

   always_comb begin
      case (uw.cond)
         gtl_pkg::COND_ALWAYS:   jump = 1'b1;
         gtl_pkg::COND_NO_ITEM:  jump = !accept || (n_sat == '0);
         gtl_pkg::COND_SEARCH:   jump = (prod < PW'(n_ff));
         gtl_pkg::COND_DIV_MORE: jump = (div_cnt_ff != gtl_pkg::DIV_CNT_W'(1));
         gtl_pkg::COND_MORE:     jump = !(fire && is_last);
         default:                jump = 1'b0;
      endcase
   end

   always_comb begin
      area_x_in = area_x_ff;
      area_y_in = area_y_ff;
      area_w_in = area_w_ff;
      area_h_in = area_h_ff;
      if (csr_we) begin
         unique case (csr_index)
            gtl_pkg::CSR_AREA_X:      area_x_in = csr_wdata;
            gtl_pkg::CSR_AREA_Y:      area_y_in = csr_wdata;
            gtl_pkg::CSR_AREA_WIDTH:  area_w_in = csr_wdata;
            gtl_pkg::CSR_AREA_HEIGHT: area_h_in = csr_wdata;
            default:                  area_x_in = area_x_ff;
         endcase
      end
   end

   always_comb begin
      step_in    = jump ? uw.target : step_ff + gtl_pkg::STEP_W'(1);
      n_in       = n_ff;
      cols_in    = cols_ff;
      rows_in    = rows_ff;
      rem_in     = rem_ff;
      nw_in      = nw_ff;
      nh_in      = nh_ff;
      nwr_in     = nwr_ff;
      lw_in      = lw_ff;
      lh_in      = lh_ff;
      lr_in      = lr_ff;
      idx_in     = idx_ff;
      col_in     = col_ff;
      row_in     = row_ff;
      xacc_in    = xacc_ff;
      yacc_in    = yacc_ff;
      div_num_in = div_num_ff;
      div_den_in = div_den_ff;
      div_rem_in = div_rem_ff;
      div_cnt_in = div_cnt_ff;

      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_x_in      = rsp_x_ff;
      rsp_y_in      = rsp_y_ff;
      rsp_w_in      = rsp_w_ff;
      rsp_h_in      = rsp_h_ff;
      rsp_border_in = rsp_border_ff;
      rsp_plus_in   = rsp_plus_ff;
      rsp_last_in   = rsp_last_ff;

      unique case (uw.op)
         gtl_pkg::OP_LOAD: begin
            n_in    = n_sat;
            cols_in = CW'(1);
         end
         gtl_pkg::OP_SEARCH: begin
            if (prod < PW'(n_ff)) begin
               cols_in = cols_ff + CW'(1);
            end
         end
         gtl_pkg::OP_ROWS: begin
            if (prod >= PW'(n_ff) && (cols_ff > CW'(1))) begin
               rows_in = cols_ff - CW'(1);
            end else begin
               rows_in = cols_ff;
            end
         end
         gtl_pkg::OP_REM: begin
            rem_in = (last_cnt == cols_ff) ? '0 : last_cnt;
         end
         gtl_pkg::OP_DIV_H: begin
            div_num_in = area_h_ff;
            div_den_in = rows_ff;
            div_rem_in = '0;
            div_cnt_in = gtl_pkg::DIV_CNT_W'(AW);
         end
         gtl_pkg::OP_DIV_STEP: begin
            div_rem_in = div_ge ? CW'(div_part - {1'b0, div_den_ff}) : CW'(div_part);
            div_num_in = {div_num_ff[AW-2:0], div_ge};
            div_cnt_in = div_cnt_ff - gtl_pkg::DIV_CNT_W'(1);
         end
         gtl_pkg::OP_DIV_W: begin
            nh_in      = div_num_ff;
            lh_in      = div_rem_ff;
            div_num_in = area_w_ff;
            div_den_in = cols_ff;
            div_rem_in = '0;
            div_cnt_in = gtl_pkg::DIV_CNT_W'(AW);
         end
         gtl_pkg::OP_DIV_R: begin
            nw_in      = div_num_ff;
            lw_in      = div_rem_ff;
            div_num_in = area_w_ff;
            div_den_in = rem_ff;
            div_rem_in = '0;
            div_cnt_in = gtl_pkg::DIV_CNT_W'(AW);
         end
         gtl_pkg::OP_SETUP: begin
            nwr_in  = div_num_ff;
            lr_in   = div_rem_ff;
            idx_in  = '0;
            col_in  = '0;
            row_in  = '0;
            xacc_in = '0;
            yacc_in = '0;
         end
         gtl_pkg::OP_EMIT: begin
            if (fire) begin
               rsp_valid_in  = 1'b1;
               rsp_x_in      = XW'(xacc_ff) + XW'(area_x_ff) + XW'(border);
               rsp_y_in      = XW'(yacc_ff) + XW'(area_y_ff);
               rsp_h_in      = nh_ff + ah;
               rsp_border_in = border;
               rsp_plus_in   = border && !tee;
               rsp_last_in   = is_last;
               if (border && (w_full != '0)) begin
                  rsp_w_in = w_full - AW'(1);
               end else if (border) begin
                  rsp_w_in = '0;
               end else begin
                  rsp_w_in = w_full;
               end
               idx_in = idx_ff + CW'(1);
               if (last_col) begin
                  col_in  = '0;
                  row_in  = row_ff + CW'(1);
                  xacc_in = '0;
                  yacc_in = yacc_ff + nh_ff;
               end else begin
                  col_in  = col_ff + CW'(1);
                  xacc_in = xacc_ff + nw_sel;
               end
            end
         end
         default: begin
            n_in = n_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= gtl_pkg::STEP_LOAD;
         rsp_valid_ff <= 1'b0;
         area_x_ff    <= gtl_pkg::AREA_X_RST;
         area_y_ff    <= gtl_pkg::AREA_Y_RST;
         area_w_ff    <= gtl_pkg::AREA_WIDTH_RST;
         area_h_ff    <= gtl_pkg::AREA_HEIGHT_RST;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         area_x_ff    <= area_x_in;
         area_y_ff    <= area_y_in;
         area_w_ff    <= area_w_in;
         area_h_ff    <= area_h_in;
      end
      n_ff          <= n_in;
      cols_ff       <= cols_in;
      rows_ff       <= rows_in;
      rem_ff        <= rem_in;
      nw_ff         <= nw_in;
      nh_ff         <= nh_in;
      nwr_ff        <= nwr_in;
      lw_ff         <= lw_in;
      lh_ff         <= lh_in;
      lr_ff         <= lr_in;
      idx_ff        <= idx_in;
      col_ff        <= col_in;
      row_ff        <= row_in;
      xacc_ff       <= xacc_in;
      yacc_ff       <= yacc_in;
      div_num_ff    <= div_num_in;
      div_den_ff    <= div_den_in;
      div_rem_ff    <= div_rem_in;
      div_cnt_ff    <= div_cnt_in;
      rsp_x_ff      <= rsp_x_in;
      rsp_y_ff      <= rsp_y_in;
      rsp_w_ff      <= rsp_w_in;
      rsp_h_ff      <= rsp_h_in;
      rsp_border_ff <= rsp_border_in;
      rsp_plus_ff   <= rsp_plus_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_tile_x        = rsp_x_ff;
   assign rsp_tile_y        = rsp_y_ff;
   assign rsp_tile_width    = rsp_w_ff;
   assign rsp_tile_height   = rsp_h_ff;
   assign rsp_has_border    = rsp_border_ff;
   assign rsp_junction_plus = rsp_plus_ff;
   assign rsp_last_tile     = rsp_last_ff;

endmodule

`default_nettype wire
